/* rtl/atlf_pkg.sv */
// Shared constants and the CORDIC angle table for the tilt level filter.
package atlf_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned TAB_LEN      = 24;
  localparam int unsigned TAB_IDX_W    = 5;
  localparam int unsigned TAB_FRAC     = 24;
  localparam int unsigned ANGLE_FRAC   = 8;
  localparam int unsigned ACC_W        = 34;
  localparam int unsigned ANGLE_W      = 17;
  localparam int unsigned AXIS_W       = 16;
  localparam int unsigned WEIGHT_W     = 9;
  localparam int unsigned DEG_W        = 7;
  localparam int unsigned COL_W        = 7;
  localparam int unsigned AXIS_SCALE   = 14;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd26;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 9'd256;

  localparam logic signed [ACC_W-1:0] ANG_180 = 34'sd180 <<< TAB_FRAC;
  localparam logic signed [ACC_W-1:0] ANG_LIM = 34'sd180 <<< ANGLE_FRAC;
  localparam logic signed [ANGLE_W-1:0] LIM45 = 17'sd45 <<< ANGLE_FRAC;

  localparam logic [DEG_W-1:0] DEG_OFFSET = 7'd45;
  localparam logic [13:0]      COL_SCALE  = 14'd127;
  localparam logic [23:0]      COL_RECIP  = 24'd728;
  localparam int unsigned      COL_SHIFT  = 16;
  localparam logic [13:0]      COL_DIV    = 14'd90;

  localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_LEN] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115
  };

endpackage

/* rtl/atlf_cordic.sv */
// Iterative vectoring CORDIC that turns an (x, z) sample into a Q8.8 angle.
module atlf_cordic #(
  parameter int unsigned CORDIC_STEPS = atlf_pkg::CORDIC_STEPS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [atlf_pkg::AXIS_W-1:0]    accel_x_i,
  input  logic signed [atlf_pkg::AXIS_W-1:0]    accel_z_i,
  output logic                                  done_o,
  output logic signed [atlf_pkg::ANGLE_W-1:0]   angle_o
);

  localparam int unsigned Steps = (CORDIC_STEPS > atlf_pkg::TAB_LEN) ?
                                  atlf_pkg::TAB_LEN : CORDIC_STEPS;
  localparam int unsigned CntW = $clog2(Steps);
  localparam int unsigned RndShift = atlf_pkg::TAB_FRAC - atlf_pkg::ANGLE_FRAC;
  localparam logic signed [atlf_pkg::ACC_W-1:0] RndHalf =
    34'sd1 <<< (RndShift - 1);
  localparam logic [CntW-1:0] CntLast = CntW'(Steps - 1);

  typedef enum logic [1:0] {S_IDLE, S_ROT, S_RND} state_e;

  state_e                             state_q;
  logic [CntW-1:0]                    cnt_q;
  logic signed [atlf_pkg::ACC_W-1:0]  u_q, v_q, ang_q;
  logic                               zero_q;
  logic                               done_q;
  logic signed [atlf_pkg::ANGLE_W-1:0] angle_q;

  logic signed [atlf_pkg::ACC_W-1:0]  x_sh, z_sh;
  logic signed [atlf_pkg::ACC_W-1:0]  du, dv, tab;
  logic signed [atlf_pkg::ACC_W-1:0]  u_d, v_d, ang_d;
  logic signed [atlf_pkg::ACC_W-1:0]  rnd, rsh, rsat;

  assign x_sh = atlf_pkg::ACC_W'(accel_x_i) <<< atlf_pkg::AXIS_SCALE;
  assign z_sh = atlf_pkg::ACC_W'(accel_z_i) <<< atlf_pkg::AXIS_SCALE;

  always_comb begin
    du  = v_q >>> cnt_q;
    dv  = u_q >>> cnt_q;
    tab = atlf_pkg::ATAN_TAB[atlf_pkg::TAB_IDX_W'(cnt_q)];
    if (!v_q[atlf_pkg::ACC_W-1]) begin
      u_d   = u_q + du;
      v_d   = v_q - dv;
      ang_d = ang_q + tab;
    end else begin
      u_d   = u_q - du;
      v_d   = v_q + dv;
      ang_d = ang_q - tab;
    end
  end

  always_comb begin
    rnd = ang_q + RndHalf;
    rsh = rnd >>> RndShift;
    if (rsh > atlf_pkg::ANG_LIM) begin
      rsat = atlf_pkg::ANG_LIM;
    end else if (rsh < -atlf_pkg::ANG_LIM) begin
      rsat = -atlf_pkg::ANG_LIM;
    end else begin
      rsat = rsh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cnt_q  <= '0;
            zero_q <= (accel_x_i == '0) && (accel_z_i == '0);
            if (accel_z_i[atlf_pkg::AXIS_W-1]) begin
              u_q   <= -z_sh;
              v_q   <= -x_sh;
              ang_q <= accel_x_i[atlf_pkg::AXIS_W-1] ? -atlf_pkg::ANG_180
                                                     : atlf_pkg::ANG_180;
            end else begin
              u_q   <= z_sh;
              v_q   <= x_sh;
              ang_q <= '0;
            end
            state_q <= S_ROT;
          end
        end
        S_ROT: begin
          u_q   <= u_d;
          v_q   <= v_d;
          ang_q <= ang_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= S_RND;
          end
        end
        S_RND: begin
          angle_q <= zero_q ? '0 : atlf_pkg::ANGLE_W'(rsat);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

/* rtl/atlf_filter.sv */
// One-pole angle smoother with clamp, whole-degree truncation and column map.
module atlf_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [atlf_pkg::ANGLE_W-1:0]   raw_i,
  input  logic [atlf_pkg::WEIGHT_W-1:0]         weight_i,
  output logic                                  done_o,
  output logic signed [atlf_pkg::ANGLE_W-1:0]   smoothed_o,
  output logic signed [atlf_pkg::DEG_W-1:0]     degrees_o,
  output logic [atlf_pkg::COL_W-1:0]            column_o
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_DEG, S_COL, S_FIX} state_e;

  state_e                               state_q;
  logic                                 done_q;
  logic signed [atlf_pkg::ANGLE_W-1:0]  raw_q;
  logic [atlf_pkg::WEIGHT_W-1:0]        w_q;
  logic signed [27:0]                   prod_q;
  logic signed [atlf_pkg::ANGLE_W-1:0]  filt_q;
  logic signed [atlf_pkg::DEG_W-1:0]    deg_q;
  logic [13:0]                          p_q;
  logic [atlf_pkg::COL_W-1:0]           q0_q;
  logic [atlf_pkg::COL_W-1:0]           col_q;

  logic signed [17:0]                   diff;
  logic signed [27:0]                   prod;
  logic signed [19:0]                   acc;
  logic signed [atlf_pkg::ANGLE_W-1:0]  clamp;
  logic [atlf_pkg::ANGLE_W-1:0]         mag;
  logic [atlf_pkg::DEG_W-1:0]           dmag;
  logic signed [atlf_pkg::DEG_W-1:0]    deg;
  logic [atlf_pkg::DEG_W-1:0]           n;
  logic [23:0]                          q0_full;
  logic [13:0]                          rem;

  assign diff = 18'(raw_q) - 18'(filt_q);
  assign prod = 28'(diff) * 28'($signed({1'b0, w_q}));
  assign acc  = 20'(filt_q) + 20'(prod_q >>> 8);

  always_comb begin
    if (filt_q > atlf_pkg::LIM45) begin
      clamp = atlf_pkg::LIM45;
    end else if (filt_q < -atlf_pkg::LIM45) begin
      clamp = -atlf_pkg::LIM45;
    end else begin
      clamp = filt_q;
    end
    mag  = clamp[atlf_pkg::ANGLE_W-1] ? atlf_pkg::ANGLE_W'(-clamp)
                                      : atlf_pkg::ANGLE_W'(clamp);
    dmag = atlf_pkg::DEG_W'(mag >> atlf_pkg::ANGLE_FRAC);
    deg  = clamp[atlf_pkg::ANGLE_W-1] ? atlf_pkg::DEG_W'(-dmag)
                                      : atlf_pkg::DEG_W'(dmag);
    n    = atlf_pkg::DEG_W'(deg) + atlf_pkg::DEG_OFFSET;
  end

  assign q0_full = (24'(p_q) * atlf_pkg::COL_RECIP) >> atlf_pkg::COL_SHIFT;
  assign rem     = p_q - 14'(14'(q0_q) * atlf_pkg::COL_DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      filt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            raw_q   <= raw_i;
            w_q     <= (weight_i > atlf_pkg::WEIGHT_MAX) ? atlf_pkg::WEIGHT_MAX
                                                         : weight_i;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= prod;
          state_q <= S_ACC;
        end
        S_ACC: begin
          filt_q  <= atlf_pkg::ANGLE_W'(acc);
          state_q <= S_DEG;
        end
        S_DEG: begin
          deg_q   <= deg;
          p_q     <= 14'(n) * atlf_pkg::COL_SCALE;
          state_q <= S_COL;
        end
        S_COL: begin
          q0_q    <= atlf_pkg::COL_W'(q0_full);
          state_q <= S_FIX;
        end
        S_FIX: begin
          col_q   <= (rem >= atlf_pkg::COL_DIV) ? q0_q + 1'b1 : q0_q;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o     = done_q;
  assign smoothed_o = filt_q;
  assign degrees_o  = deg_q;
  assign column_o   = col_q;

endmodule

/* rtl/accel_tilt_level_filter.sv */
// Top level of the tilt level filter: handshake, weight register, output register.
//
//   channel | signals                                  | dir | accepted when
//   in      | in_valid_i, in_ready_o, accel_x_i/z_i    | in  | in_valid_i & in_ready_o
//   out     | out_valid_o, out_ready_i, 4 result ports | out | out_valid_o & out_ready_i
//   cfg     | cfg_we_i, cfg_wdata_i                    | in  | cfg_we_i
//
// Each item runs through the CORDIC loop with one rotation per cycle, and then
// through five filter and column steps.
// Reset clears the smoothed angle to zero and the weight to 26.
// in_ready_o is high only while no item is in work; a finished item waits in
// the output register, and the next item may be taken while it waits.
module accel_tilt_level_filter #(
  parameter int unsigned CORDIC_STEPS = atlf_pkg::CORDIC_STEPS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [atlf_pkg::AXIS_W-1:0]    accel_x_i,
  input  logic signed [atlf_pkg::AXIS_W-1:0]    accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [atlf_pkg::ANGLE_W-1:0]   raw_angle_o,
  output logic signed [atlf_pkg::ANGLE_W-1:0]   smoothed_angle_o,
  output logic signed [atlf_pkg::DEG_W-1:0]     clamped_degrees_o,
  output logic [atlf_pkg::COL_W-1:0]            bubble_column_o,
  input  logic                                  cfg_we_i,
  input  logic [atlf_pkg::WEIGHT_W-1:0]         cfg_wdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_CORD, S_FILT, S_PUSH} state_e;

  state_e                               state_q;
  logic [atlf_pkg::WEIGHT_W-1:0]        weight_q;
  logic                                 out_valid_q;
  logic signed [atlf_pkg::ANGLE_W-1:0]  raw_q, smooth_q;
  logic signed [atlf_pkg::DEG_W-1:0]    deg_q;
  logic [atlf_pkg::COL_W-1:0]           col_q;

  logic                                 in_fire;
  logic                                 cord_done;
  logic signed [atlf_pkg::ANGLE_W-1:0]  cord_angle;
  logic                                 filt_start;
  logic                                 filt_done;
  logic signed [atlf_pkg::ANGLE_W-1:0]  filt_smooth;
  logic signed [atlf_pkg::DEG_W-1:0]    filt_deg;
  logic [atlf_pkg::COL_W-1:0]           filt_col;
  logic                                 slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign filt_start = (state_q == S_CORD) && cord_done;
  assign slot_free  = !out_valid_q || out_ready_i;

  atlf_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .accel_x_i(accel_x_i),
    .accel_z_i(accel_z_i),
    .done_o   (cord_done),
    .angle_o  (cord_angle)
  );

  atlf_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (filt_start),
    .raw_i     (cord_angle),
    .weight_i  (weight_q),
    .done_o    (filt_done),
    .smoothed_o(filt_smooth),
    .degrees_o (filt_deg),
    .column_o  (filt_col)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      weight_q    <= atlf_pkg::WEIGHT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        weight_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            state_q <= S_FILT;
          end
        end
        S_FILT: begin
          if (filt_done) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (slot_free) begin
            raw_q       <= cord_angle;
            smooth_q    <= filt_smooth;
            deg_q       <= filt_deg;
            col_q       <= filt_col;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign raw_angle_o       = raw_q;
  assign smoothed_angle_o  = smooth_q;
  assign clamped_degrees_o = deg_q;
  assign bubble_column_o   = col_q;

endmodule

/* verif/tb.sv */
// Testbench for accel_tilt_level_filter: directed and random samples checked by a scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_ROUNDS = 16;
  localparam int FRAC_BITS = 8;
  localparam int LATENCY = CORDIC_ROUNDS + 10;

  localparam longint ATAN_DEG_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  localparam logic signed [15:0] DIR_X [12] = '{
    16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767,
    -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, -16'sd1, -16'sd1
  };
  localparam logic signed [15:0] DIR_Z [12] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767,
    -16'sd32768, -16'sd32768, 16'sd32767, -16'sd1, -16'sd1, 16'sd32767
  };
  localparam int unsigned PHASE_WEIGHT [9] = '{26, 0, 1, 511, 257, 128, 0, 255, 256};

  typedef struct packed {
    logic signed [16:0] raw;
    logic signed [16:0] smooth;
    logic signed [6:0]  deg;
    logic [6:0]         col;
  } tilt_result_t;

  class tilt_scoreboard;
    int unsigned weight;
    longint level;
    tilt_result_t waiting[$];
    int errors;

    function new();
      weight = 26;
      level = 0;
      errors = 0;
    endfunction

    function longint tilt_angle_q8(longint x, longint z);
      longint u, v, ang, du, dv, r, lim;
      if (x == 0 && z == 0) return 0;
      u = z * 16384;
      v = x * 16384;
      ang = 0;
      if (z < 0) begin
        u = -u;
        v = -v;
        ang = (x >= 0) ? (longint'(180) <<< 24) : -(longint'(180) <<< 24);
      end
      for (int i = 0; i < CORDIC_ROUNDS; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (v >= 0) begin
          u += du;
          v -= dv;
          ang += ATAN_DEG_Q24[i];
        end else begin
          u -= du;
          v += dv;
          ang -= ATAN_DEG_Q24[i];
        end
      end
      r = (ang + (longint'(1) <<< (24 - FRAC_BITS - 1))) >>> (24 - FRAC_BITS);
      lim = longint'(180) <<< FRAC_BITS;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function void note_sample(logic signed [15:0] x, logic signed [15:0] z);
      longint raw, c, deg, col, w, lim45;
      tilt_result_t r;
      raw = tilt_angle_q8(x, z);
      w = (weight > 256) ? 256 : weight;
      level += ((raw - level) * w) >>> 8;
      lim45 = longint'(45) <<< FRAC_BITS;
      c = level;
      if (c > lim45) c = lim45;
      if (c < -lim45) c = -lim45;
      deg = (c >= 0) ? (c >>> FRAC_BITS) : -((-c) >>> FRAC_BITS);
      col = (deg + 45) * 127 / 90;
      r.raw = raw[16:0];
      r.smooth = level[16:0];
      r.deg = deg[6:0];
      r.col = col[6:0];
      waiting.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_result(tilt_result_t got);
      tilt_result_t exp;
      if (waiting.size() == 0) begin
        report_mismatch("result with no sample pending");
        return;
      end
      exp = waiting.pop_front();
      if (got.raw !== exp.raw)
        report_mismatch($sformatf("raw_angle %0d, want %0d", got.raw, exp.raw));
      if (got.smooth !== exp.smooth)
        report_mismatch($sformatf("smoothed_angle %0d, want %0d", got.smooth, exp.smooth));
      if (got.deg !== exp.deg)
        report_mismatch($sformatf("clamped_degrees %0d, want %0d", got.deg, exp.deg));
      if (got.col !== exp.col)
        report_mismatch($sformatf("bubble_column %0d, want %0d", got.col, exp.col));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [atlf_pkg::AXIS_W-1:0] accel_x_i = '0;
  logic signed [atlf_pkg::AXIS_W-1:0] accel_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [atlf_pkg::ANGLE_W-1:0] raw_angle_o;
  logic signed [atlf_pkg::ANGLE_W-1:0] smoothed_angle_o;
  logic signed [atlf_pkg::DEG_W-1:0] clamped_degrees_o;
  logic [atlf_pkg::COL_W-1:0] bubble_column_o;
  logic cfg_we_i = 1'b0;
  logic [atlf_pkg::WEIGHT_W-1:0] cfg_wdata_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int stall_cycles = 0;
  tilt_scoreboard sb = new();

  accel_tilt_level_filter uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .accel_x_i(accel_x_i),
    .accel_z_i(accel_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .raw_angle_o(raw_angle_o),
    .smoothed_angle_o(smoothed_angle_o),
    .clamped_degrees_o(clamped_degrees_o),
    .bubble_column_o(bubble_column_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({raw_angle_o, smoothed_angle_o, clamped_degrees_o, bubble_column_o});
  end

  function automatic int pick_axis();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = int'($urandom_range(0, 128)) - 64;
      2: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = -1;
          2: v = 0;
          3: v = 1;
          default: v = 32767;
        endcase
      end
      default: begin
        v = int'($urandom_range(8192, 32767));
        if ($urandom_range(0, 1) == 1) v = -v - 1;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    accel_x_i = x;
    accel_z_i = z;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(x, z);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.waiting.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_weight(int unsigned w);
    cfg_we_i = 1'b1;
    cfg_wdata_i = w[atlf_pkg::WEIGHT_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.weight = w & 32'h1ff;
  endtask

  initial begin
    int base_x, base_z, run_left;
    logic signed [15:0] x, z;
    run_left = 0;
    base_x = 0;
    base_z = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 84;
    foreach (DIR_X[i]) send_sample(DIR_X[i], DIR_Z[i]);
    wait_drained();
    write_weight(256);
    foreach (DIR_X[i]) send_sample(DIR_X[i], DIR_Z[i]);

    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      case (phase / 3)
        0: begin send_idle_pct = 37; recv_idle_pct = 84; end
        1: begin send_idle_pct = 84; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_weight((phase == 6) ? $urandom_range(0, 511) : PHASE_WEIGHT[phase]);
      if (phase == 1 || phase == 6) stall_cycles = 400;
      repeat (210) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        if ($urandom_range(0, 99) < 30) begin
          x = sat16(pick_axis());
          z = sat16(pick_axis());
        end else begin
          if (run_left == 0) begin
            base_x = pick_axis();
            base_z = pick_axis();
            run_left = $urandom_range(1, 40);
          end
          run_left--;
          x = sat16(base_x + int'($urandom_range(0, 32)) - 16);
          z = sat16(base_z + int'($urandom_range(0, 32)) - 16);
        end
        send_sample(x, z);
      end
    end

    wait_drained();
    repeat (2 * LATENCY) @(negedge clk_i);
    if (sb.waiting.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.waiting.size()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
